@@ hw/rtl/fsfla_pkg.sv @@
// Package with shared types and constants for the fixed slot free-list allocator.
package fsfla_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 256;

  localparam int unsigned ADDR_W = 20;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned POOL_W = 9;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN = 4'd3;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd12;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd6;
  localparam logic [POOL_W-1:0] POOL_RESET = 9'd256;
  localparam logic [ADDR_W-1:0] ADDR_MASK = 20'hFFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SHIFT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SLOTS = 1'b1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic pop_done;
  } dp_cmd_t;

  typedef struct packed {
    logic list_nonempty;
  } dp_status_t;

endpackage

@@ hw/rtl/fsfla_if.sv @@
// Handshake interfaces for the request and response channels of the allocator.
interface fsfla_req_if import fsfla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, output kind, output free_address, input ready);
  modport sink (input valid, input kind, input free_address, output ready);
endinterface

interface fsfla_rsp_if import fsfla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [ADDR_W-1:0] slot_address;

  modport source (output valid, output ok, output slot_address, input ready);
  modport sink (input valid, input ok, input slot_address, output ready);
endinterface

@@ hw/rtl/fixed_slot_free_list_allocator_unit.sv @@
// Top level of the fixed slot free-list allocator.
// A free, a carve or a rejected request responds the cycle after acceptance; a pop first
// passes through ST_POP, since the next list head comes from a registered link memory read.
// One free or carve is taken per cycle unless the response stalls; none is taken in ST_POP.
// Reset clears the list, the counters and the response valid, and sets slot_shift to 6 and
// pool_slots to 256; the link memory is not cleared and needs no clearing pass.
module fixed_slot_free_list_allocator_unit import fsfla_pkg::*; #(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fsfla_req_if.sink             in_if,
  fsfla_rsp_if.source           out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  fsfla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_kind_i   (in_if.kind),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fsfla_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .kind_i         (in_if.kind),
    .free_address_i (in_if.free_address),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .ok_o           (out_if.ok),
    .slot_address_o (out_if.slot_address)
  );

  // A pop completes in the cycle after the allocate that started it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop_done |-> $past(cmd.accept) && ($past(in_if.kind) == KIND_ALLOC))
    else $error("pop completed without a preceding allocate");

  // No new transaction is taken while a pop is finishing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop_done |-> !(in_if.valid && in_if.ready))
    else $error("transaction accepted during pop");

  // A successful free always leaves a nonempty list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && (in_if.kind == KIND_FREE)) |=> (!out_if.ok || status.list_nonempty))
    else $error("successful free left the list empty");

endmodule

@@ hw/rtl/fsfla_ctrl.sv @@
// Controller state machine that sequences transactions and owns the response valid.
module fsfla_ctrl import fsfla_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_kind_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        start_pop;
  logic        load_result;

  always_comb begin
    state_d = state_q;
    in_ready_o = 1'b0;
    cmd_o = '0;
    start_pop = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        cmd_o.accept = in_valid_i && in_ready_o;
        start_pop = cmd_o.accept && (in_kind_i == KIND_ALLOC) && status_i.list_nonempty;
        if (start_pop) begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        cmd_o.pop_done = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    load_result = (cmd_o.accept && !start_pop) || cmd_o.pop_done;
    out_valid_d = (out_valid_q && !out_ready_i) || load_result;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/fsfla_dp.sv @@
// Datapath with configuration, free-list head, counters, link memory and result registers.
module fsfla_dp import fsfla_pkg::*; #(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic                  kind_i,
  input  logic [ADDR_W-1:0]     free_address_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  ok_o,
  output logic [ADDR_W-1:0]     slot_address_o
);

  localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CMP_W = (CNT_W > POOL_W) ? CNT_W : POOL_W;
  localparam int unsigned WIDE_W = (CNT_W > ADDR_W) ? CNT_W : ADDR_W;

  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic [POOL_W-1:0]  pool_q, pool_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   len_q, len_d;
  logic [CNT_W-1:0]   carve_q, carve_d;
  logic               ok_q, ok_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [IDX_W-1:0]   link_mem [MAX_SLOTS];
  logic [IDX_W-1:0]   rdata_q;

  logic [SHIFT_W-1:0] eff_shift;
  logic               nonempty;
  logic               carve_avail;
  logic [ADDR_W-1:0]  free_idx_w;
  logic [IDX_W-1:0]   free_idx;
  logic               aligned;
  logic               free_ok;
  logic               mem_we;
  logic [31:0]        pop_addr_w;
  logic [31:0]        carve_addr_w;

  always_comb begin
    if (shift_q < SHIFT_MIN) begin
      eff_shift = SHIFT_MIN;
    end else if (shift_q > SHIFT_MAX) begin
      eff_shift = SHIFT_MAX;
    end else begin
      eff_shift = shift_q;
    end
  end

  assign nonempty = (len_q != '0);
  assign status_o.list_nonempty = nonempty;
  assign carve_avail = (carve_q < CNT_W'(MAX_SLOTS)) && (CMP_W'(carve_q) < CMP_W'(pool_q));
  assign free_idx_w = free_address_i >> eff_shift;
  assign free_idx = free_idx_w[IDX_W-1:0];
  assign aligned = ((free_address_i & ~(ADDR_MASK << eff_shift)) == '0);
  assign free_ok = aligned && (WIDE_W'(free_idx_w) < WIDE_W'(carve_q)) && (len_q < carve_q);
  assign pop_addr_w = 32'(head_q) << eff_shift;
  assign carve_addr_w = 32'(carve_q) << eff_shift;

  always_comb begin
    shift_d = shift_q;
    pool_d = pool_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SLOT_SHIFT: shift_d = cfg_data_i[SHIFT_W-1:0];
        CFG_POOL_SLOTS: pool_d = cfg_data_i[POOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    head_d = head_q;
    len_d = len_q;
    carve_d = carve_q;
    ok_d = ok_q;
    addr_d = addr_q;
    mem_we = 1'b0;
    if (cmd_i.pop_done) begin
      head_d = rdata_q;
      len_d = len_q - CNT_W'(1);
      ok_d = 1'b1;
      addr_d = pop_addr_w[ADDR_W-1:0];
    end else if (cmd_i.accept) begin
      ok_d = 1'b0;
      addr_d = '0;
      if (kind_i == KIND_FREE) begin
        if (free_ok) begin
          mem_we = 1'b1;
          head_d = free_idx;
          len_d = len_q + CNT_W'(1);
          ok_d = 1'b1;
        end
      end else if (!nonempty && carve_avail) begin
        carve_d = carve_q + CNT_W'(1);
        ok_d = 1'b1;
        addr_d = carve_addr_w[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_RESET;
      pool_q <= POOL_RESET;
      head_q <= '0;
      len_q <= '0;
      carve_q <= '0;
    end else begin
      shift_q <= shift_d;
      pool_q <= pool_d;
      head_q <= head_d;
      len_q <= len_d;
      carve_q <= carve_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q <= ok_d;
    addr_q <= addr_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[free_idx] <= head_q;
    end
    rdata_q <= link_mem[head_q];
  end

  assign ok_o = ok_q;
  assign slot_address_o = addr_q;

endmodule

@@ tb/fixed_slot_free_list_allocator_unit_tb.sv @@
// Self-checking testbench for the fixed slot free-list allocator under mixed handshake stalls.
`timescale 1ns / 1ps

module fixed_slot_free_list_allocator_unit_tb;
  import fsfla_pkg::*;

  typedef struct {
    logic              ok;
    logic [ADDR_W-1:0] slot_address;
  } alloc_response_t;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  fsfla_req_if req_bus ();
  fsfla_rsp_if rsp_bus ();

  fixed_slot_free_list_allocator_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (req_bus),
    .out_if      (rsp_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copy of the allocator state and its registers.
  logic [7:0]         link_copy [MAX_SLOTS_DEF];
  logic [7:0]         head_copy;
  logic               nonempty_copy;
  logic [POOL_W-1:0]  carve_copy;
  logic [POOL_W-1:0]  length_copy;
  logic [SHIFT_W-1:0] shift_copy;
  logic [POOL_W-1:0]  pool_copy;

  alloc_response_t expected_responses[$];
  int held_slots[$];

  int src_idle_pct;
  int sink_stall_pct;
  int mismatch_count;
  int requests_sent;
  int responses_checked;
  int granted_allocs;
  int accepted_frees;
  int rejected_requests;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int active_shift();
    if (shift_copy < SHIFT_MIN) return int'(SHIFT_MIN);
    if (shift_copy > SHIFT_MAX) return int'(SHIFT_MAX);
    return int'(shift_copy);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic predict_response(input logic kind, input logic [ADDR_W-1:0] addr);
    alloc_response_t rsp;
    int sh;
    int slot;
    logic [ADDR_W-1:0] idx_wide;
    logic aligned;
    int hits[$];
    sh = active_shift();
    rsp.ok = 1'b0;
    rsp.slot_address = '0;
    if (kind == KIND_ALLOC) begin
      slot = -1;
      if (nonempty_copy) begin
        slot = head_copy;
        head_copy = link_copy[slot];
        if (length_copy > 0) length_copy--;
        if (length_copy == 0) nonempty_copy = 1'b0;
      end else if (carve_copy < ((pool_copy > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : pool_copy)) begin
        slot = carve_copy;
        carve_copy++;
      end
      if (slot >= 0) begin
        rsp.ok = 1'b1;
        rsp.slot_address = ADDR_W'(slot << sh);
        held_slots = {held_slots, slot};
        granted_allocs++;
      end
    end else begin
      idx_wide = addr >> sh;
      aligned = (addr & ADDR_W'((1 << sh) - 1)) == '0;
      if (aligned && idx_wide < carve_copy && length_copy < carve_copy) begin
        link_copy[idx_wide[7:0]] = head_copy;
        head_copy = idx_wide[7:0];
        nonempty_copy = 1'b1;
        length_copy++;
        rsp.ok = 1'b1;
        accepted_frees++;
        hits = held_slots.find_first_index(x) with (x == int'(idx_wide));
        if (hits.size() != 0) held_slots.delete(hits[0]);
      end
    end
    if (!rsp.ok) rejected_requests++;
    expected_responses = {expected_responses, rsp};
  endtask

  task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.kind <= kind;
    req_bus.free_address <= addr;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    requests_sent++;
    predict_response(kind, addr);
  endtask

  task automatic wait_for_drain();
    req_bus.valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_allocator(input logic [SHIFT_W-1:0] shift, input logic [POOL_W-1:0] pool);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_SLOT_SHIFT;
    cfg_data_i <= CFG_DATA_W'(shift);
    @(posedge clk_i);
    cfg_index_i <= CFG_POOL_SLOTS;
    cfg_data_i <= pool;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shift_copy = shift;
    pool_copy = pool;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin : response_checker
    alloc_response_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_responses.size() == 0) begin
        report_mismatch($sformatf("unexpected response ok=%0b addr=%05h",
                                  rsp_bus.ok, rsp_bus.slot_address));
      end else begin
        want = expected_responses.pop_front();
        responses_checked++;
        if (rsp_bus.ok !== want.ok) begin
          report_mismatch($sformatf("ok is %b, expected %b", rsp_bus.ok, want.ok));
        end
        if (rsp_bus.slot_address !== want.slot_address) begin
          report_mismatch($sformatf("slot_address is %05h, expected %05h",
                                    rsp_bus.slot_address, want.slot_address));
        end
      end
    end
  end

  task automatic test_directed_cases();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_request(KIND_ALLOC, 20'h00000);
    send_request(KIND_ALLOC, 20'hFFFFF);
    send_request(KIND_FREE, 20'h00041);
    send_request(KIND_FREE, 20'hFFFFF);
    send_request(KIND_FREE, 20'(5 << 6));
    send_request(KIND_FREE, 20'h00040);
    send_request(KIND_FREE, 20'h00000);
    send_request(KIND_FREE, 20'h00000);
    send_request(KIND_ALLOC, 20'h00000);
    send_request(KIND_ALLOC, 20'h00000);
    send_request(KIND_ALLOC, 20'h00000);
    send_request(KIND_ALLOC, 20'h00000);
    wait_for_drain();
    program_allocator(4'd15, 9'd2);
    send_request(KIND_ALLOC, 20'h00000);
    send_request(KIND_FREE, 20'h03000);
    send_request(KIND_ALLOC, 20'h00000);
    send_request(KIND_ALLOC, 20'h00000);
    send_request(KIND_FREE, 20'hFF000);
    wait_for_drain();
    program_allocator(4'd0, 9'd0);
    send_request(KIND_FREE, 20'h00010);
    send_request(KIND_ALLOC, 20'h00000);
    send_request(KIND_ALLOC, 20'h00000);
    send_request(KIND_FREE, 20'h00001);
    wait_for_drain();
    program_allocator(4'd12, 9'd511);
    send_request(KIND_ALLOC, 20'h00000);
    send_request(KIND_FREE, 20'h04000);
    send_request(KIND_ALLOC, 20'h00000);
    wait_for_drain();
  endtask

  task automatic send_random_request();
    int sel;
    int sh;
    int slot;
    logic [ADDR_W-1:0] addr;
    sh = active_shift();
    sel = $urandom_range(99);
    addr = ADDR_W'($urandom());
    if (sel < 45) begin
      send_request(KIND_ALLOC, addr);
    end else if (sel < 82 && held_slots.size() != 0) begin
      slot = held_slots[$urandom_range(held_slots.size() - 1)];
      send_request(KIND_FREE, ADDR_W'(slot << sh));
    end else begin
      case ($urandom_range(3))
        0: begin
          send_request(KIND_FREE, addr);
        end
        1: begin
          addr = ADDR_W'(($urandom_range(255) << sh) | $urandom_range((1 << sh) - 1, 1));
          send_request(KIND_FREE, addr);
        end
        2: begin
          slot = (carve_copy > 255) ? $urandom_range(255) : $urandom_range(255, carve_copy);
          send_request(KIND_FREE, ADDR_W'(slot << sh));
        end
        default: begin
          slot = $urandom_range((carve_copy == 0) ? 0 : carve_copy - 1);
          send_request(KIND_FREE, ADDR_W'(slot << sh));
        end
      endcase
    end
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
    logic [SHIFT_W-1:0] shift;
    logic [POOL_W-1:0] pool;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    for (int seg = 0; seg < 2; seg++) begin
      wait_for_drain();
      case ($urandom_range(5))
        0: shift = 4'd0;
        1: shift = SHIFT_MIN;
        2: shift = SHIFT_MAX;
        3: shift = 4'd15;
        default: shift = SHIFT_W'($urandom_range(15));
      endcase
      case ($urandom_range(6))
        0: pool = 9'd0;
        1: pool = 9'd1;
        2: pool = 9'd256;
        3: pool = 9'd511;
        4: pool = POOL_W'($urandom_range(64, 2));
        default: pool = POOL_W'($urandom_range(511));
      endcase
      program_allocator(shift, pool);
      for (int i = 0; i < n_items / 2; i++) begin
        if (i == n_items / 8 || $urandom_range(59) == 0) wait_for_drain();
        send_random_request();
      end
    end
    wait_for_drain();
  endtask

  initial begin
    mismatch_count = 0;
    requests_sent = 0;
    responses_checked = 0;
    granted_allocs = 0;
    accepted_frees = 0;
    rejected_requests = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    head_copy = '0;
    nonempty_copy = 1'b0;
    carve_copy = '0;
    length_copy = '0;
    shift_copy = SHIFT_RESET;
    pool_copy = POOL_RESET;
    for (int i = 0; i < MAX_SLOTS_DEF; i++) link_copy[i] = '0;
    rst_ni <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.kind <= KIND_ALLOC;
    req_bus.free_address <= '0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_SLOT_SHIFT;
    cfg_data_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_traffic(0, 0, 250);
    test_random_traffic(53, 0, 250);
    test_random_traffic(0, 53, 250);
    test_random_traffic(25, 25, 250);

    wait_for_drain();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d requests over several pool sizes, slot sizes and stall patterns.",
             requests_sent);
    $display("Checked %0d responses: %0d allocations granted, %0d frees taken, %0d rejected.",
             responses_checked, granted_allocs, accepted_frees, rejected_requests);
    if (mismatch_count == 0 && expected_responses.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout with %0d responses still outstanding.", expected_responses.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/fsfla_pkg.sv
hw/rtl/fsfla_if.sv
hw/rtl/fsfla_ctrl.sv
hw/rtl/fsfla_dp.sv
hw/rtl/fixed_slot_free_list_allocator_unit.sv
tb/fixed_slot_free_list_allocator_unit_tb.sv
